/* hdl/mexp_pkg.sv */
// Package for the modular exponentiation block: widths, reset constants,
// configuration register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int MOD_BITS_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int EXP_W        = 32;
  localparam int CFG_IDX_W    = 2;

  localparam int PRIME_P    = 40009;
  localparam int PRIME_Q    = 40031;
  localparam int PUBLIC_EXP = 65537;

  localparam logic [DATA_W-1:0] MODULUS_RST  = DATA_W'(PRIME_P * PRIME_Q);
  localparam logic [EXP_W-1:0]  EXPONENT_RST = EXP_W'(PUBLIC_EXP);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODULUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXPONENT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_MULT,
    ST_SQUARE,
    ST_FINISH
  } mexp_state_t;

endpackage

/* hdl/modular_exponentiation.sv */
// Modular exponentiation top level: sequencer, configuration registers and
// output register around one shared bit-serial modular multiplier.
// Depends on mexp_pkg and mexp_mulmod.
`timescale 1ns / 1ps

// Each item carries one base; the block returns base to the power of the
// exponent register, reduced by the modulus register, by right-to-left
// square-and-multiply. The base is first reduced by one pass of the shared
// multiplier. Then each exponent bit up to the highest set bit costs one
// decode step, one squaring (except for the highest bit) and, if the bit is
// set, one extra multiplication. Each pass of the multiplier holds the
// sequencer until the multiplier reports done, and a stalled result holds it
// in its final state. An exponent of zero goes straight from the reduction
// to the final state. The input is not ready while an item is in progress.
// An exponent of zero yields 1, and a modulus of zero makes the arithmetic
// wrap modulo 2^MOD_BITS. Registers may be written only while the block is
// idle.

module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_base_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_power_result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int N = MOD_BITS;

  mexp_state_t         state_r, state_nxt;
  logic [DATA_W-1:0]   modulus_r, modulus_nxt;
  logic [EXP_W-1:0]    exponent_r, exponent_nxt;
  logic [EXP_W-1:0]    exp_r, exp_nxt;
  logic [N-1:0]        acc_r, acc_nxt;
  logic [N-1:0]        sq_r, sq_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;

  logic [63:0]         mod_ext;
  logic [63:0]         base_ext;
  logic [63:0]         acc_ext;
  logic [N-1:0]        mod_n;
  logic [N-1:0]        base_n;

  logic                mm_start;
  logic [N-1:0]        mm_x;
  logic [N-1:0]        mm_y;
  logic                mm_done;
  logic [N-1:0]        mm_result;

  assign mod_ext  = {32'd0, modulus_r};
  assign base_ext = {32'd0, in_base_value};
  assign acc_ext  = 64'(acc_r);
  assign mod_n    = mod_ext[N-1:0];
  assign base_n   = base_ext[N-1:0];

  mexp_mulmod #(
    .N(N)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (mod_n),
    .done   (mm_done),
    .result (mm_result)
  );

  always_comb begin
    state_nxt     = state_r;
    modulus_nxt   = modulus_r;
    exponent_nxt  = exponent_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mm_start      = 1'b0;
    mm_x          = acc_r;
    mm_y          = sq_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MODULUS:  modulus_nxt  = cfg_wdata;
        CFG_IDX_EXPONENT: exponent_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mm_start  = 1'b1;
          mm_x      = N'(1);
          mm_y      = base_n;
          exp_nxt   = exponent_r;
          acc_nxt   = N'(1);
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          sq_nxt    = mm_result;
          state_nxt = (exp_r == '0) ? ST_FINISH : ST_BIT;
        end
      end
      ST_BIT: begin
        mm_start = 1'b1;
        if (exp_r[0]) begin
          state_nxt = ST_MULT;
        end else begin
          mm_x      = sq_r;
          state_nxt = ST_SQUARE;
        end
      end
      ST_MULT: begin
        if (mm_done) begin
          acc_nxt = mm_result;
          if (exp_r[EXP_W-1:1] == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            mm_start  = 1'b1;
            mm_x      = sq_r;
            state_nxt = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        if (mm_done) begin
          sq_nxt    = mm_result;
          exp_nxt   = exp_r >> 1;
          state_nxt = (exp_r[EXP_W-1:1] == '0) ? ST_FINISH : ST_BIT;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_ext[DATA_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MODULUS_RST;
      exponent_r  <= EXPONENT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      modulus_r   <= modulus_nxt;
      exponent_r  <= exponent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_r      <= exp_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_data_r;

endmodule

/* hdl/mexp_mulmod.sv */
// Shared bit-serial modular multiplier: x * y mod m by shift-and-add,
// one multiplier bit per cycle. A modulus of zero wraps modulo 2^N.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module mexp_mulmod #(
  parameter int N = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] x,
  input  logic [N-1:0] y,
  input  logic [N-1:0] m,
  output logic         done,
  output logic [N-1:0] result
);

  localparam int CW = $clog2(N);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [N-1:0]  acc_r, acc_nxt;
  logic [N-1:0]  x_r, x_nxt;
  logic [N-1:0]  y_r, y_nxt;
  logic [N-1:0]  m_r, m_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [N-1:0]  dbl;
  logic [N-1:0]  step;

  // Sum of two residues, reduced once; modulus zero means plain wrap.
  function automatic logic [N-1:0] add_mod(input logic [N-1:0] a,
                                           input logic [N-1:0] b,
                                           input logic [N-1:0] md);
    logic [N:0] s;
    logic [N:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, md};
    if (md == '0) begin
      return s[N-1:0];
    end else if (s >= {1'b0, md}) begin
      return d[N-1:0];
    end else begin
      return s[N-1:0];
    end
  endfunction

  always_comb begin
    dbl  = add_mod(acc_r, acc_r, m_r);
    step = y_r[N-1] ? add_mod(dbl, x_r, m_r) : dbl;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      x_nxt    = x;
      y_nxt    = y;
      m_nxt    = m;
      cnt_nxt  = CW'(N - 1);
    end else if (busy_r) begin
      acc_nxt = step;
      y_nxt   = {y_r[N-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

/* hdl/mexp_checker.sv */
// Port-level checks for the modular exponentiation block, and the bind
// that attaches them to the top level. Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_checker
  import mexp_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DATA_W-1:0]    out_power_result
);

  // After reset the block is idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // An accepted item keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted item");

  // No result can appear in the cycle after an item is accepted.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared immediately after accept");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_power_result)))
    else $error("stalled result changed or dropped");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_power_result (out_power_result)
);

/* dv/testbench.sv */
// Self-checking testbench for the modular exponentiation block: a directed table of
// register settings and bases, then random register settings with random bases.
// Depends on mexp_pkg and the modular_exponentiation RTL.
`timescale 1ns / 1ps

module testbench
  import mexp_pkg::*;
;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = CFG_IDX_W'(3);
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM   = 255;

  typedef struct {
    logic [DATA_W-1:0] modulus;
    logic [EXP_W-1:0]  exponent;
    logic [DATA_W-1:0] base;
    bit                known;
    logic [DATA_W-1:0] power;
  } power_vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DATA_W-1:0] in_base_value = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [DATA_W-1:0] out_power_result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  logic [DATA_W-1:0] expected_powers [$];
  logic [DATA_W-1:0] want_power;
  logic [DATA_W-1:0] cur_modulus = MODULUS_RST;
  logic [EXP_W-1:0]  cur_exponent = EXPONENT_RST;
  bit idle_on = 1'b1;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_used = 1;

  power_vector_t directed_vectors [N_DIRECTED] = '{
    '{MODULUS_RST, EXPONENT_RST, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODULUS_RST, EXPONENT_RST, 32'h0000_0001, 1'b1, 32'h0000_0001},
    '{MODULUS_RST, EXPONENT_RST, 32'h0000_0002, 1'b0, 32'h0000_0000},
    '{MODULUS_RST, EXPONENT_RST, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{MODULUS_RST, EXPONENT_RST, MODULUS_RST,   1'b1, 32'h0000_0000},
    '{MODULUS_RST, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{MODULUS_RST, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{32'h0000_0001, 32'h0000_0000, 32'h0000_3039, 1'b1, 32'h0000_0001},
    '{32'h0000_0001, EXPONENT_RST, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{32'h0000_0001, EXPONENT_RST, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, 32'h0000_0003, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0000, 32'h0000_0003, 32'h0001_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, 32'h0000_0003, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 32'h0000_0000},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000},
    '{32'h0000_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{32'h0000_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000},
    '{32'h0000_0002, 32'h0000_0001, 32'h0000_0005, 1'b1, 32'h0000_0001},
    '{32'h0000_9C49, 32'h0000_0002, 32'h0000_9C48, 1'b1, 32'h0000_0001},
    '{32'h0000_9C49, 32'h0000_0002, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000},
    '{32'h8000_0000, 32'h0000_0002, 32'h5555_5555, 1'b0, 32'h0000_0000}
  };

  modular_exponentiation dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_power_result (out_power_result),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [DATA_W-1:0] mul_mod_word(input logic [DATA_W-1:0] a,
                                                     input logic [DATA_W-1:0] b,
                                                     input logic [DATA_W-1:0] m);
    logic [2*DATA_W-1:0] prod;
    prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    if (m == '0) begin
      return prod[DATA_W-1:0];
    end
    return DATA_W'(prod % {{DATA_W{1'b0}}, m});
  endfunction

  // Right-to-left square-and-multiply; a zero modulus means plain 32-bit wraparound.
  function automatic logic [DATA_W-1:0] power_mod(input logic [DATA_W-1:0] b,
                                                  input logic [DATA_W-1:0] m,
                                                  input logic [EXP_W-1:0] e);
    logic [DATA_W-1:0] sq;
    logic [DATA_W-1:0] acc;
    logic [EXP_W-1:0] bits;
    sq = (m == '0) ? b : b % m;
    acc = DATA_W'(1);
    bits = e;
    while (bits != '0) begin
      if (bits[0]) begin
        acc = mul_mod_word(acc, sq, m);
      end
      sq = mul_mod_word(sq, sq, m);
      bits = bits >> 1;
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    errors++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_MODULUS) begin
      cur_modulus = data;
    end else if (idx == CFG_IDX_EXPONENT) begin
      cur_exponent = EXP_W'(data);
    end
    @(posedge clk);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_powers.size() != 0 || !in_ready) @(posedge clk);
  endtask

  task automatic load_setting(input logic [DATA_W-1:0] m, input logic [EXP_W-1:0] e);
    drain_block();
    write_reg(CFG_IDX_MODULUS, m);
    write_reg(CFG_IDX_EXPONENT, DATA_W'(e));
    settings_used++;
  endtask

  task automatic send_base(input logic [DATA_W-1:0] b, input bit known,
                           input logic [DATA_W-1:0] power);
    int gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base_value <= b;
    do @(posedge clk); while (!in_ready);
    expected_powers.push_back(known ? power : power_mod(b, cur_modulus, cur_exponent));
    items_sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_modulus();
    case ($urandom_range(0, 7))
      0: return DATA_W'($urandom_range(2, 255));
      1: return DATA_W'($urandom_range(256, 65535));
      2: return 32'hFFFF_FFFF - DATA_W'($urandom_range(0, 15));
      3: return DATA_W'($urandom_range(0, 1));
      default: return $urandom | 32'h0000_0002;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_base(input logic [DATA_W-1:0] m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DATA_W'(1);
      2: return m - DATA_W'(1);
      3: return m;
      4, 5: return (m == '0) ? $urandom : $urandom % m;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_powers.size() == 0) begin
        report_mismatch($sformatf("result %h with no item outstanding", out_power_result));
      end else begin
        want_power = expected_powers.pop_front();
        results_seen++;
        if (out_power_result !== want_power) begin
          report_mismatch($sformatf("power_result %h, expected %h",
                                    out_power_result, want_power));
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 24) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", expected_powers.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] m;
    logic [EXP_W-1:0] e;
    int w;
    int n;
    int random_items;
    int phase;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Writes to the unused indexes must leave the reset values in place.
    write_reg(CFG_IDX_SPARE_A, 32'h0000_0003);
    write_reg(CFG_IDX_SPARE_B, 32'hFFFF_FFFF);

    foreach (directed_vectors[i]) begin
      if (directed_vectors[i].modulus != cur_modulus ||
          directed_vectors[i].exponent != cur_exponent) begin
        load_setting(directed_vectors[i].modulus, directed_vectors[i].exponent);
      end
      send_base(directed_vectors[i].base, directed_vectors[i].known,
                directed_vectors[i].power);
    end

    random_items = 0;
    phase = 0;
    while (random_items < N_RANDOM) begin
      m = pick_modulus();
      if (phase == 2) begin
        e = $urandom;
      end else begin
        w = $urandom_range(0, 12);
        e = (w == 0) ? '0 : EXP_W'($urandom >> (32 - w));
      end
      idle_on = (random_items < N_RANDOM - 30) ? ($urandom_range(0, 3) != 0) : 1'b0;
      load_setting(m, e);
      n = $urandom_range(20, 30);
      repeat (n) begin
        send_base(pick_base(m), 1'b0, '0);
        random_items++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);

    $display("Sent %0d items (%0d from the directed table) under %0d register settings.",
             items_sent, N_DIRECTED, settings_used);
    $display("Checked %0d results; %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
